[rtl/lwd_pkg.sv]
// Shared constants and types of the LZSS window decoder.
package lwd_pkg;

    localparam int WINDOW_SIZE_DEF = 4096;
    localparam int OFF_W           = 12;
    localparam int LEN_W           = 5;
    localparam int MATCH_BIAS      = 3;
    localparam int MATCH_MAX       = 18;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0] SPACE_BYTE = 8'h20;

    localparam logic CFG_IN_LENGTH = 1'b0;
    localparam logic CFG_OUT_LIMIT = 1'b1;

    typedef enum logic {
        CMD_LIT,
        CMD_MATCH
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [7:0]       data;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

[rtl/lzss_window_decoder_top.sv]
// Top level of the LZSS window decoder.
//
// Compressed bytes enter on the slave stream, one byte per request, and
// decompressed bytes leave on the master stream with tlast marking the last
// byte caused by one input byte. Two registers (input length, output limit)
// are written through the configuration channel, which is always ready.
// A front end parses flag bytes and tokens at one byte per cycle while the
// queue has room and posts literal and match commands to a four-entry queue;
// the back end plays them out of a window memory at one output byte per cycle
// while the output buffer has room, save that each match first passes the
// offset reduction states RED1 and RED2; the copy engine takes no new command
// until a match is done. A match is 3 to 18 bytes long unless the output
// limit cuts it shorter. A literal passes the queue, the issue register and
// the output buffer; a match byte is also read from the window memory.
// Reset clears all counts and empties queue and output buffer; a fill count
// makes every window entry not yet written read as a space, so no clearing
// pass is needed.
// When the receiver stalls the two-entry output buffer fills, the copy
// engine pauses, the queue fills and the input ready drops.
module lzss_window_decoder_top #(
    parameter int WINDOW_SIZE = lwd_pkg::WINDOW_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [7:0] out_byte, [39:8] out_count
    output logic        o_m_axis_tlast,   // run_last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    lwd_pkg::t_cmd    push_cmd;
    lwd_pkg::t_cmd    head_cmd;
    lwd_pkg::t_q_stat q_stat;
    logic             push;
    logic             pop;
    logic [7:0]       out_byte;
    logic [31:0]      out_count;

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {out_count, out_byte};

    lwd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_byte   (i_s_axis_tdata),
        .o_in_ready  (o_s_axis_tready),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    lwd_queue #(
        .DEPTH (lwd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    lwd_back #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (head_cmd),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_byte   (out_byte),
        .o_last   (o_m_axis_tlast),
        .o_count  (out_count)
    );

endmodule

[rtl/lwd_front.sv]
// Front end: takes compressed bytes, tracks flag and token state, issues literal and match commands.
module lwd_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_index,
    input  logic [31:0]             i_cfg_data,
    input  logic                    i_in_valid,
    input  logic [7:0]              i_in_byte,
    output logic                    o_in_ready,
    input  lwd_pkg::t_q_stat        i_q_stat,
    output logic                    o_push,
    output lwd_pkg::t_cmd           o_cmd
);

    logic [31:0] r_in_length;
    logic [31:0] r_out_limit;
    logic [31:0] r_in_count, n_in_count;
    logic [31:0] r_proj, n_proj;
    logic [7:0]  r_flag_bits, n_flag_bits;
    logic [3:0]  r_flag_left, n_flag_left;
    logic        r_phase, n_phase;
    logic [7:0]  r_off_low, n_off_low;

    logic                       accept;
    logic [31:0]                remain;
    logic [lwd_pkg::LEN_W-1:0]  len_full;
    logic [lwd_pkg::LEN_W-1:0]  len_eff;

    assign o_in_ready = !i_q_stat.full;
    assign accept     = i_in_valid && !i_q_stat.full;

    // The front keeps its own projection of the output count so that the
    // output limit can be applied before the back end has caught up.
    assign remain   = r_out_limit - r_proj;
    assign len_full = {1'b0, i_in_byte[3:0]} + lwd_pkg::LEN_W'(lwd_pkg::MATCH_BIAS);
    assign len_eff  = (remain < {{(32-lwd_pkg::LEN_W){1'b0}}, len_full}) ?
                      remain[lwd_pkg::LEN_W-1:0] : len_full;

    always_comb begin
        n_in_count  = r_in_count;
        n_proj      = r_proj;
        n_flag_bits = r_flag_bits;
        n_flag_left = r_flag_left;
        n_phase     = r_phase;
        n_off_low   = r_off_low;
        o_push      = 1'b0;
        o_cmd       = '0;
        if (accept && (r_in_count < r_in_length)) begin
            n_in_count = r_in_count + 32'd1;
            if (r_proj < r_out_limit) begin
                if (r_phase) begin
                    n_phase    = 1'b0;
                    o_push     = 1'b1;
                    o_cmd.kind = lwd_pkg::CMD_MATCH;
                    o_cmd.off  = {i_in_byte[7:4], r_off_low};
                    o_cmd.len  = len_eff;
                    n_proj     = r_proj + {{(32-lwd_pkg::LEN_W){1'b0}}, len_eff};
                end else if (r_flag_left == 4'd0) begin
                    n_flag_bits = i_in_byte;
                    n_flag_left = 4'd8;
                end else begin
                    n_flag_bits = {1'b0, r_flag_bits[7:1]};
                    n_flag_left = r_flag_left - 4'd1;
                    if (r_flag_bits[0]) begin
                        o_push     = 1'b1;
                        o_cmd.kind = lwd_pkg::CMD_LIT;
                        o_cmd.data = i_in_byte;
                        n_proj     = r_proj + 32'd1;
                    end else begin
                        n_off_low = i_in_byte;
                        n_phase   = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_length <= '1;
            r_out_limit <= '1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lwd_pkg::CFG_IN_LENGTH: r_in_length <= i_cfg_data;
                lwd_pkg::CFG_OUT_LIMIT: r_out_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_count  <= '0;
            r_proj      <= '0;
            r_flag_bits <= '0;
            r_flag_left <= '0;
            r_phase     <= 1'b0;
            r_off_low   <= '0;
        end else begin
            r_in_count  <= n_in_count;
            r_proj      <= n_proj;
            r_flag_bits <= n_flag_bits;
            r_flag_left <= n_flag_left;
            r_phase     <= n_phase;
            r_off_low   <= n_off_low;
        end
    end

endmodule

[rtl/lwd_queue.sv]
// Short command queue between the front end and the copy engine.
module lwd_queue #(
    parameter int DEPTH = lwd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lwd_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output lwd_pkg::t_cmd    o_cmd,
    output lwd_pkg::t_q_stat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lwd_pkg::t_cmd  r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_cmd        = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/lwd_back.sv]
// Back end: window memory, copy engine and two-entry output buffer.
module lwd_back #(
    parameter int WINDOW_SIZE = lwd_pkg::WINDOW_SIZE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lwd_pkg::t_cmd    i_cmd,
    input  lwd_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_byte,
    output logic             o_last,
    output logic [31:0]      o_count
);

    localparam int AW          = $clog2(WINDOW_SIZE);
    localparam int OFF_W       = lwd_pkg::OFF_W;
    localparam int LEN_W       = lwd_pkg::LEN_W;
    localparam int WPOS_RST    = (2 * WINDOW_SIZE - lwd_pkg::MATCH_MAX) % WINDOW_SIZE;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP       = (1 << RECIP_SHIFT) / WINDOW_SIZE;
    localparam int RECIP_W     = $clog2(RECIP + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RED1,
        ST_RED2,
        ST_COPY
    } t_state;

    logic [7:0] r_window [WINDOW_SIZE];
    logic [7:0] r_mem_q;

    t_state            r_state, n_state;
    logic [OFF_W-1:0]  r_off, n_off;
    logic [OFF_W-1:0]  r_q, n_q;
    logic [LEN_W-1:0]  r_left, n_left;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]     r_wpos;
    logic [AW:0]       r_fill;
    logic [31:0]       r_produced;

    logic              r_s1_valid, n_s1_valid;
    logic              r_s1_lit, n_s1_lit;
    logic              r_s1_fwd, n_s1_fwd;
    logic              r_s1_space, n_s1_space;
    logic              r_s1_last, n_s1_last;
    logic [7:0]        r_s1_data, n_s1_data;

    logic [7:0]        r_ob_byte  [2];
    logic              r_ob_last  [2];
    logic [31:0]       r_ob_count [2];
    logic              r_ob_rd;
    logic              r_ob_wr;
    logic [1:0]        r_ob_cnt;

    logic [7:0]                    s1_byte;
    logic [31:0]                   produced_inc;
    logic                          pop_out;
    logic [2:0]                    occ_next;
    logic                          can_issue;
    logic [AW:0]                   wr_dist;
    logic                          written;
    logic                          fwd;
    logic [OFF_W+RECIP_W-1:0]      prod;
    logic [OFF_W:0]                qw;
    logic [OFF_W:0]                rem_raw;
    logic [OFF_W:0]                rem_red;

    assign s1_byte = (r_s1_lit || r_s1_fwd) ? r_s1_data :
                     r_s1_space ? lwd_pkg::SPACE_BYTE : r_mem_q;
    assign produced_inc = r_produced + 32'd1;

    assign o_valid = (r_ob_cnt != 2'd0);
    assign o_byte  = r_ob_byte[r_ob_rd];
    assign o_last  = r_ob_last[r_ob_rd];
    assign o_count = r_ob_count[r_ob_rd];
    assign pop_out = o_valid && i_ready;

    // A byte issued now passes the issue register before it lands in the output
    // buffer, so there must be room for it even if the receiver stalls meanwhile.
    assign occ_next  = {1'b0, r_ob_cnt} + {2'b0, r_s1_valid} - {2'b0, pop_out};
    assign can_issue = (occ_next <= 3'd1);

    // Window entries are written in order from the reset write position, so
    // an entry has been written once its distance from there is below the fill.
    assign wr_dist = (r_rd_ptr >= AW'(WPOS_RST)) ?
                     ({1'b0, r_rd_ptr} - (AW+1)'(WPOS_RST)) :
                     ({1'b0, r_rd_ptr} + (AW+1)'(WINDOW_SIZE) - (AW+1)'(WPOS_RST));
    assign written = (wr_dist < r_fill);
    assign fwd     = r_s1_valid && (r_wpos == r_rd_ptr);

    // Offset modulo the window size by reciprocal multiplication.
    assign prod    = {{RECIP_W{1'b0}}, r_off} * {{OFF_W{1'b0}}, RECIP_W'(RECIP)};
    assign qw      = (OFF_W+1)'(r_q * WINDOW_SIZE);
    assign rem_raw = {1'b0, r_off} - qw;
    assign rem_red = (rem_raw >= (OFF_W+1)'(WINDOW_SIZE)) ?
                     rem_raw - (OFF_W+1)'(WINDOW_SIZE) : rem_raw;

    always_comb begin
        n_state    = r_state;
        n_off      = r_off;
        n_q        = r_q;
        n_left     = r_left;
        n_rd_ptr   = r_rd_ptr;
        n_s1_valid = 1'b0;
        n_s1_lit   = 1'b0;
        n_s1_fwd   = 1'b0;
        n_s1_space = 1'b0;
        n_s1_last  = 1'b0;
        n_s1_data  = r_s1_data;
        o_pop      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    if (i_cmd.kind == lwd_pkg::CMD_LIT) begin
                        if (can_issue) begin
                            o_pop      = 1'b1;
                            n_s1_valid = 1'b1;
                            n_s1_lit   = 1'b1;
                            n_s1_last  = 1'b1;
                            n_s1_data  = i_cmd.data;
                        end
                    end else begin
                        o_pop   = 1'b1;
                        n_off   = i_cmd.off;
                        n_left  = i_cmd.len;
                        n_state = ST_RED1;
                    end
                end
            end
            ST_RED1: begin
                n_q     = OFF_W'(prod >> RECIP_SHIFT);
                n_state = ST_RED2;
            end
            ST_RED2: begin
                n_rd_ptr = AW'(rem_red);
                n_state  = ST_COPY;
            end
            ST_COPY: begin
                if (can_issue) begin
                    n_s1_valid = 1'b1;
                    n_s1_fwd   = fwd;
                    n_s1_space = !written;
                    n_s1_data  = s1_byte;
                    n_s1_last  = (r_left == LEN_W'(1));
                    n_rd_ptr   = (r_rd_ptr == AW'(WINDOW_SIZE - 1)) ? '0 : r_rd_ptr + 1'b1;
                    n_left     = r_left - 1'b1;
                    if (r_left == LEN_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mem_q <= r_window[r_rd_ptr];
        if (r_s1_valid) begin
            r_window[r_wpos] <= s1_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_left     <= '0;
            r_rd_ptr   <= '0;
            r_wpos     <= AW'(WPOS_RST);
            r_fill     <= '0;
            r_produced <= '0;
            r_s1_valid <= 1'b0;
            r_s1_lit   <= 1'b0;
            r_s1_fwd   <= 1'b0;
            r_s1_space <= 1'b0;
            r_s1_last  <= 1'b0;
            r_ob_rd    <= 1'b0;
            r_ob_wr    <= 1'b0;
            r_ob_cnt   <= '0;
        end else begin
            r_state    <= n_state;
            r_left     <= n_left;
            r_rd_ptr   <= n_rd_ptr;
            r_s1_valid <= n_s1_valid;
            r_s1_lit   <= n_s1_lit;
            r_s1_fwd   <= n_s1_fwd;
            r_s1_space <= n_s1_space;
            r_s1_last  <= n_s1_last;
            if (r_s1_valid) begin
                r_wpos     <= (r_wpos == AW'(WINDOW_SIZE - 1)) ? '0 : r_wpos + 1'b1;
                r_produced <= produced_inc;
                if (r_fill != (AW+1)'(WINDOW_SIZE)) begin
                    r_fill <= r_fill + 1'b1;
                end
                r_ob_wr <= !r_ob_wr;
            end
            if (pop_out) begin
                r_ob_rd <= !r_ob_rd;
            end
            r_ob_cnt <= occ_next[1:0];
        end
        r_off     <= n_off;
        r_q       <= n_q;
        r_s1_data <= n_s1_data;
        if (r_s1_valid) begin
            r_ob_byte[r_ob_wr]  <= s1_byte;
            r_ob_last[r_ob_wr]  <= r_s1_last;
            r_ob_count[r_ob_wr] <= produced_inc;
        end
    end

endmodule

[rtl/lwd_checker.sv]
// Port-level checks of the LZSS window decoder, bound to the top level.
module lwd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    logic        r_seen;
    logic [31:0] r_prev_count;
    logic        out_req;

    assign out_req = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= 1'b0;
            r_prev_count <= '0;
        end else if (out_req) begin
            r_seen       <= 1'b1;
            r_prev_count <= o_m_axis_tdata[39:8];
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output payload changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_first_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_req && !r_seen |-> o_m_axis_tdata[39:8] == 32'd1)
        else $error("first output count is not one");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_req && r_seen |-> o_m_axis_tdata[39:8] == r_prev_count + 32'd1)
        else $error("output count skipped or repeated");

endmodule

bind lzss_window_decoder_top lwd_checker u_lwd_checker (.*);
